/* hw/rtl/sbi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbi_pkg
// Shared constants and types for the segment / box intersection unit.
// ----------------------------------------------------------------------------
package sbi_pkg;

   localparam int COORD_BITS_DEF = 24;

   // box edges, walked corner -> +x -> +x+y -> +y -> corner
   localparam int EDGE_COUNT  = 4;
   localparam int EDGE_BOTTOM = 0;
   localparam int EDGE_RIGHT  = 1;
   localparam int EDGE_TOP    = 2;
   localparam int EDGE_LEFT   = 3;

   typedef logic [EDGE_COUNT-1:0] edge_mask_type;

endpackage

/* hw/rtl/segment_box_intersect_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_box_intersect_unit
// Tests a ray segment against the bottom, right, top and left edges of an axis-aligned box.
// ----------------------------------------------------------------------------
// pipeline: the edge that accepts a req beat loads the input register, then the
//   product and result registers are loaded in turn, and rsp_tvalid follows
// throughput: one beat per cycle; empty stages keep filling while rsp_tready is
//   low, and req_tready drops only when all three stages are full
// reset clears the stage valid flags; the data registers are not reset
// ----------------------------------------------------------------------------
module segment_box_intersect_unit
   import sbi_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // ray_origin_x, ray_origin_y, ray_dir_x, ray_dir_y, box_x, box_y,
   // box_width, box_height, zero pad
   input  logic [((8*COORD_BITS-2+7)/8)*8-1:0] req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // hit, zero pad
   output logic [7:0]           rsp_tdata
);

   localparam int CB = COORD_BITS;
   localparam int VW = CB + 2;
   localparam int PW = 2 * VW;

   logic signed [CB-1:0] ox_ff, oy_ff, rx_ff, ry_ff, bx_ff, by_ff;
   logic        [CB-2:0] w_ff, h_ff;
   logic                 v1_ff, v2_ff, v3_ff;
   logic                 v1_in, v2_in, v3_in;
   logic                 ld1, ld2, ld3;

   logic signed [PW-1:0] vx0_ry, vx1_ry, rx_vy0, rx_vy2, w_ry, rx_h;
   edge_mask_type        b_ok;
   logic                 hit;

   assign ld3 = !v3_ff || rsp_tready;
   assign ld2 = !v2_ff || ld3;
   assign ld1 = !v1_ff || ld2;

   assign req_tready = ld1;

   assign v1_in = ld1 ? req_tvalid : v1_ff;
   assign v2_in = ld2 ? v1_ff : v2_ff;
   assign v3_in = ld3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         ox_ff <= $signed(req_tdata[0*CB +: CB]);
         oy_ff <= $signed(req_tdata[1*CB +: CB]);
         rx_ff <= $signed(req_tdata[2*CB +: CB]);
         ry_ff <= $signed(req_tdata[3*CB +: CB]);
         bx_ff <= $signed(req_tdata[4*CB +: CB]);
         by_ff <= $signed(req_tdata[5*CB +: CB]);
         w_ff  <= req_tdata[6*CB +: CB-1];
         h_ff  <= req_tdata[7*CB-1 +: CB-1];
      end
   end

   sbi_edge_products #(.CB(CB), .VW(VW), .PW(PW)) u_products (
      .clock        (clock),
      .en           (ld2),
      .ray_origin_x (ox_ff),
      .ray_origin_y (oy_ff),
      .ray_dir_x    (rx_ff),
      .ray_dir_y    (ry_ff),
      .box_x        (bx_ff),
      .box_y        (by_ff),
      .box_width    (w_ff),
      .box_height   (h_ff),
      .vx0_ry_ff    (vx0_ry),
      .vx1_ry_ff    (vx1_ry),
      .rx_vy0_ff    (rx_vy0),
      .rx_vy2_ff    (rx_vy2),
      .w_ry_ff      (w_ry),
      .rx_h_ff      (rx_h),
      .b_ok_ff      (b_ok)
   );

   sbi_edge_decide #(.CB(CB), .PW(PW)) u_decide (
      .clock  (clock),
      .en     (ld3),
      .vx0_ry (vx0_ry),
      .vx1_ry (vx1_ry),
      .rx_vy0 (rx_vy0),
      .rx_vy2 (rx_vy2),
      .w_ry   (w_ry),
      .rx_h   (rx_h),
      .b_ok   (b_ok),
      .hit_ff (hit)
   );

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = {7'b0000000, hit};

   // full pipeline with a stalled output takes no new beat
   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff && v3_ff && !rsp_tready) |-> !req_tready)
      else $error("beat accepted into a full stalled pipeline");

   // an accepted beat lands in the input stage
   a_accept_lands : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> v1_ff)
      else $error("accepted beat lost at input stage");

   // a beat in the input stage moves on when the product stage is free
   a_stage_moves : assert property (@(posedge clock) disable iff (reset)
      (v1_ff && ld2) |=> v2_ff)
      else $error("beat lost between input and product stages");

   // reset leaves the pipeline empty
   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> (!v1_ff && !v2_ff && !v3_ff))
      else $error("pipeline not empty after reset");

endmodule

/* hw/rtl/sbi_range_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbi_range_check
// Tests whether the quotient num / den lies in (0,1] without dividing.
// ----------------------------------------------------------------------------
module sbi_range_check #(
   parameter int W = 26
) (
   input  logic signed [W-1:0] num,
   input  logic signed [W-1:0] den,
   output logic                ok
);

   // a zero denominator falls into the negative branch and always fails
   always_comb begin
      if (den > 0) begin
         ok = (num > 0) && (num <= den);
      end else begin
         ok = (num < 0) && (num >= den);
      end
   end

endmodule

/* hw/rtl/sbi_edge_products.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbi_edge_products
// Forms the edge offsets, registers the six cross-product terms and the ray
// parameter tests of all four box edges.
// ----------------------------------------------------------------------------
module sbi_edge_products
   import sbi_pkg::*;
#(
   parameter int CB = COORD_BITS_DEF,
   parameter int VW = CB + 2,
   parameter int PW = 2 * VW
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [CB-1:0] ray_origin_x,
   input  logic signed [CB-1:0] ray_origin_y,
   input  logic signed [CB-1:0] ray_dir_x,
   input  logic signed [CB-1:0] ray_dir_y,
   input  logic signed [CB-1:0] box_x,
   input  logic signed [CB-1:0] box_y,
   input  logic        [CB-2:0] box_width,
   input  logic        [CB-2:0] box_height,
   output logic signed [PW-1:0] vx0_ry_ff,
   output logic signed [PW-1:0] vx1_ry_ff,
   output logic signed [PW-1:0] rx_vy0_ff,
   output logic signed [PW-1:0] rx_vy2_ff,
   output logic signed [PW-1:0] w_ry_ff,
   output logic signed [PW-1:0] rx_h_ff,
   output edge_mask_type        b_ok_ff
);

   logic signed [VW-1:0] ox_e, oy_e, rx_e, ry_e, bx_e, by_e, w_e, h_e;
   logic signed [VW-1:0] vx0, vx1, vy0, vy2;
   logic signed [PW-1:0] vx0_ry_in, vx1_ry_in, rx_vy0_in, rx_vy2_in, w_ry_in, rx_h_in;
   edge_mask_type        b_ok_in;

   assign ox_e = {{2{ray_origin_x[CB-1]}}, ray_origin_x};
   assign oy_e = {{2{ray_origin_y[CB-1]}}, ray_origin_y};
   assign rx_e = {{2{ray_dir_x[CB-1]}}, ray_dir_x};
   assign ry_e = {{2{ray_dir_y[CB-1]}}, ray_dir_y};
   assign bx_e = {{2{box_x[CB-1]}}, box_x};
   assign by_e = {{2{box_y[CB-1]}}, box_y};
   assign w_e  = {3'b000, box_width};
   assign h_e  = {3'b000, box_height};

   // offsets from the ray origin to the near and far box corners
   assign vx0 = bx_e - ox_e;
   assign vx1 = bx_e + w_e - ox_e;
   assign vy0 = by_e - oy_e;
   assign vy2 = by_e + h_e - oy_e;

   assign vx0_ry_in = vx0 * ry_e;
   assign vx1_ry_in = vx1 * ry_e;
   assign rx_vy0_in = rx_e * vy0;
   assign rx_vy2_in = rx_e * vy2;
   assign w_ry_in   = w_e * ry_e;
   assign rx_h_in   = rx_e * h_e;

   // the edge length cancels out of the ray parameter: a zero edge length
   // is caught by the edge parameter test downstream
   sbi_range_check #(.W(VW)) u_b_bottom (
      .num (vy0),
      .den (ry_e),
      .ok  (b_ok_in[EDGE_BOTTOM])
   );

   sbi_range_check #(.W(VW)) u_b_right (
      .num (vx1),
      .den (rx_e),
      .ok  (b_ok_in[EDGE_RIGHT])
   );

   sbi_range_check #(.W(VW)) u_b_top (
      .num (vy2),
      .den (ry_e),
      .ok  (b_ok_in[EDGE_TOP])
   );

   sbi_range_check #(.W(VW)) u_b_left (
      .num (vx0),
      .den (rx_e),
      .ok  (b_ok_in[EDGE_LEFT])
   );

   always_ff @(posedge clock) begin
      if (en) begin
         vx0_ry_ff <= vx0_ry_in;
         vx1_ry_ff <= vx1_ry_in;
         rx_vy0_ff <= rx_vy0_in;
         rx_vy2_ff <= rx_vy2_in;
         w_ry_ff   <= w_ry_in;
         rx_h_ff   <= rx_h_in;
         b_ok_ff   <= b_ok_in;
      end
   end

endmodule

/* hw/rtl/sbi_edge_decide.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbi_edge_decide
// Combines the product terms into edge parameter tests and registers the hit.
// ----------------------------------------------------------------------------
module sbi_edge_decide
   import sbi_pkg::*;
#(
   parameter int CB = COORD_BITS_DEF,
   parameter int PW = 2 * (CB + 2)
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [PW-1:0] vx0_ry,
   input  logic signed [PW-1:0] vx1_ry,
   input  logic signed [PW-1:0] rx_vy0,
   input  logic signed [PW-1:0] rx_vy2,
   input  logic signed [PW-1:0] w_ry,
   input  logic signed [PW-1:0] rx_h,
   input  edge_mask_type        b_ok,
   output logic                 hit_ff
);

   localparam int AW = PW + 1;

   logic signed [AW-1:0] vx0_ry_e, vx1_ry_e, rx_vy0_e, rx_vy2_e, w_ry_e, rx_h_e;
   logic signed [AW-1:0] n_bottom, n_right, n_top, n_left;
   edge_mask_type        a_ok;
   logic                 hit_in;

   assign vx0_ry_e = {vx0_ry[PW-1], vx0_ry};
   assign vx1_ry_e = {vx1_ry[PW-1], vx1_ry};
   assign rx_vy0_e = {rx_vy0[PW-1], rx_vy0};
   assign rx_vy2_e = {rx_vy2[PW-1], rx_vy2};
   assign w_ry_e   = {w_ry[PW-1], w_ry};
   assign rx_h_e   = {rx_h[PW-1], rx_h};

   // top and right denominators are -w*ry and -rx*h, so their numerators
   // are negated to pair with w*ry and rx*h
   assign n_bottom = rx_vy0_e - vx0_ry_e;
   assign n_right  = vx1_ry_e - rx_vy0_e;
   assign n_top    = vx1_ry_e - rx_vy2_e;
   assign n_left   = rx_vy2_e - vx0_ry_e;

   sbi_range_check #(.W(AW)) u_a_bottom (
      .num (n_bottom),
      .den (w_ry_e),
      .ok  (a_ok[EDGE_BOTTOM])
   );

   sbi_range_check #(.W(AW)) u_a_right (
      .num (n_right),
      .den (rx_h_e),
      .ok  (a_ok[EDGE_RIGHT])
   );

   sbi_range_check #(.W(AW)) u_a_top (
      .num (n_top),
      .den (w_ry_e),
      .ok  (a_ok[EDGE_TOP])
   );

   sbi_range_check #(.W(AW)) u_a_left (
      .num (n_left),
      .den (rx_h_e),
      .ok  (a_ok[EDGE_LEFT])
   );

   assign hit_in = |(a_ok & b_ok);

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff <= hit_in;
      end
   end

endmodule
